// ===== rtl/lps_pkg.sv =====
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and constants for the 3-3-2 LSB pixel stego codec.
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int unsigned HDR_PIXELS = 32;
    localparam int unsigned HDR_W      = $clog2(HDR_PIXELS);

    localparam int unsigned COMP_W = 8;
    localparam int unsigned PLEN_W = 24;
    localparam int unsigned PCNT_W = 25;
    localparam int unsigned DLEN_W = 32;
    localparam int unsigned CFG_W  = 25;

    localparam logic [COMP_W-1:0] MASK_BG  = 8'hF8;
    localparam logic [COMP_W-1:0] MASK_R   = 8'hFC;
    localparam logic [COMP_W-1:0] ASCII_0  = 8'h30;
    localparam logic [COMP_W-1:0] ASCII_1  = 8'h31;

    typedef enum logic [1:0] {
        CFG_EMBED_MODE     = 2'd0,
        CFG_PAYLOAD_LENGTH = 2'd1,
        CFG_PIXEL_COUNT    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic              embed_mode;
        logic [PLEN_W-1:0] payload_length;
        logic [PCNT_W-1:0] pixel_count;
    } t_cfg;

    typedef struct packed {
        logic [COMP_W-1:0] blue;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] byte_out;
        logic              byte_valid;
        logic [DLEN_W-1:0] decoded_length;
        logic              header_error;
        logic              last;
    } t_result;

    function automatic logic [COMP_W-1:0] hidden_value(
        input logic [COMP_W-1:0] b,
        input logic [COMP_W-1:0] g,
        input logic [COMP_W-1:0] r
    );
        return {r[1:0], g[2:0], b[2:0]};
    endfunction

endpackage

// ===== rtl/lps_cfg.sv =====
// ----------------------------------------------------------------------------
// lps_cfg
// Configuration register file: embed mode, payload length, pixel count.
// ----------------------------------------------------------------------------
module lps_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [lps_pkg::CFG_W-1:0] i_cfg_wdata,
    output lps_pkg::t_cfg             o_cfg
);
    import lps_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_EMBED_MODE:     n_cfg.embed_mode     = i_cfg_wdata[0];
                CFG_PAYLOAD_LENGTH: n_cfg.payload_length = i_cfg_wdata[PLEN_W-1:0];
                CFG_PIXEL_COUNT:    n_cfg.pixel_count    = i_cfg_wdata[PCNT_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.embed_mode     <= 1'b0;
            r_cfg.payload_length <= '0;
            r_cfg.pixel_count    <= PCNT_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/lps_core.sv =====
// ----------------------------------------------------------------------------
// lps_core
// Per-pixel embed/extract logic with pixel counter and header length state.
// ----------------------------------------------------------------------------
module lps_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  lps_pkg::t_cfg              i_cfg,
    input  logic [lps_pkg::COMP_W-1:0] i_blue,
    input  logic [lps_pkg::COMP_W-1:0] i_green,
    input  logic [lps_pkg::COMP_W-1:0] i_red,
    input  logic [lps_pkg::COMP_W-1:0] i_payload_byte,
    output lps_pkg::t_result           o_result
);
    import lps_pkg::*;

    logic [PCNT_W-1:0] r_pixel_index;
    logic [PCNT_W-1:0] n_pixel_index;
    logic [DLEN_W-1:0] r_length_shift;
    logic [DLEN_W-1:0] n_length_shift;
    logic              r_error_flag;
    logic              n_error_flag;

    logic [PCNT_W-1:0] count_m1;
    logic              last;
    logic              in_header;
    logic [PCNT_W-1:0] body_index;
    logic [HDR_W-1:0]  hdr_bit;
    logic [PLEN_W-1:0] len_shifted;
    logic [COMP_W-1:0] embed_val;
    logic              write;
    logic [COMP_W-1:0] v_in;
    logic [COMP_W-1:0] b_o;
    logic [COMP_W-1:0] g_o;
    logic [COMP_W-1:0] r_o;

    always_comb begin
        count_m1    = (i_cfg.pixel_count == '0) ? '0 : i_cfg.pixel_count - PCNT_W'(1);
        last        = r_pixel_index >= count_m1;
        in_header   = r_pixel_index < PCNT_W'(HDR_PIXELS);
        body_index  = r_pixel_index - PCNT_W'(HDR_PIXELS);
        hdr_bit     = HDR_W'(HDR_PIXELS - 1) - r_pixel_index[HDR_W-1:0];
        len_shifted = i_cfg.payload_length >> hdr_bit;
        v_in        = hidden_value(i_blue, i_green, i_red);

        write     = 1'b0;
        embed_val = i_payload_byte;
        if (i_cfg.embed_mode && ({1'b0, i_cfg.payload_length} < i_cfg.pixel_count
                                 || i_cfg.pixel_count == '0 && i_cfg.payload_length == '0)) begin
            if (in_header) begin
                write     = 1'b1;
                embed_val = len_shifted[0] ? ASCII_1 : ASCII_0;
            end else if (body_index < {1'b0, i_cfg.payload_length}) begin
                write = 1'b1;
            end
        end

        b_o = i_blue;
        g_o = i_green;
        r_o = i_red;
        if (write) begin
            b_o = (i_blue  & MASK_BG) | {5'd0, embed_val[2:0]};
            g_o = (i_green & MASK_BG) | {5'd0, embed_val[5:3]};
            r_o = (i_red   & MASK_R)  | {6'd0, embed_val[7:6]};
        end

        n_length_shift = r_length_shift;
        n_error_flag   = r_error_flag;
        if (!i_cfg.embed_mode && in_header) begin
            if (v_in == ASCII_0 || v_in == ASCII_1) begin
                n_length_shift = {r_length_shift[DLEN_W-2:0], v_in[0]};
            end else begin
                n_error_flag = 1'b1;
            end
        end

        o_result.blue           = b_o;
        o_result.green          = g_o;
        o_result.red            = r_o;
        o_result.byte_out       = hidden_value(b_o, g_o, r_o);
        o_result.byte_valid     = !i_cfg.embed_mode && !in_header && !r_error_flag
                                  && (DLEN_W'(body_index) < r_length_shift);
        o_result.decoded_length = i_cfg.embed_mode ? '0 : n_length_shift;
        o_result.header_error   = i_cfg.embed_mode ? 1'b0 : n_error_flag;
        o_result.last           = last;

        n_pixel_index = r_pixel_index + PCNT_W'(1);
        if (last) begin
            n_pixel_index  = '0;
            n_length_shift = '0;
            n_error_flag   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_index  <= '0;
            r_length_shift <= '0;
            r_error_flag   <= 1'b0;
        end else if (i_fire) begin
            r_pixel_index  <= n_pixel_index;
            r_length_shift <= n_length_shift;
            r_error_flag   <= n_error_flag;
        end
    end

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && last) |=> (r_pixel_index == '0 && r_length_shift == '0 && !r_error_flag))
        else $error("state not cleared after last pixel");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !last) |=> (r_pixel_index == $past(r_pixel_index) + PCNT_W'(1)))
        else $error("pixel counter did not advance");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> ($stable(r_pixel_index) && $stable(r_length_shift)
                     && $stable(r_error_flag)))
        else $error("state changed without an item");

    a_embed_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_cfg.embed_mode && !last) |=>
            ($stable(r_length_shift) && $stable(r_error_flag)))
        else $error("embed mode touched extract state");

endmodule

// ===== rtl/lsb_pixel_stego_codec.sv =====
// ----------------------------------------------------------------------------
// lsb_pixel_stego_codec
// Throughput: one pixel per cycle while the receiver does not stall; the
//   counter and header state update once per item between the input
//   register and the result register, which hold each pixel in turn.
// Reset (synchronous, active low): clears the pixel counter, length and error
//   state, both valid stages, and sets config to extract, length 0, count 1.
// ----------------------------------------------------------------------------
module lsb_pixel_stego_codec (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [lps_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [lps_pkg::COMP_W-1:0] i_blue_in,
    input  logic [lps_pkg::COMP_W-1:0] i_green_in,
    input  logic [lps_pkg::COMP_W-1:0] i_red_in,
    input  logic [lps_pkg::COMP_W-1:0] i_payload_byte,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [lps_pkg::COMP_W-1:0] o_blue_out,
    output logic [lps_pkg::COMP_W-1:0] o_green_out,
    output logic [lps_pkg::COMP_W-1:0] o_red_out,
    output logic [lps_pkg::COMP_W-1:0] o_byte_out,
    output logic                       o_byte_valid,
    output logic [lps_pkg::DLEN_W-1:0] o_decoded_length,
    output logic                       o_header_error,
    output logic                       o_last
);
    import lps_pkg::*;

    t_cfg    cfg;
    t_result result;

    logic              r_in_valid;
    logic [COMP_W-1:0] r_blue;
    logic [COMP_W-1:0] r_green;
    logic [COMP_W-1:0] r_red;
    logic [COMP_W-1:0] r_payload_byte;
    logic              r_out_valid;
    t_result           r_result;

    logic out_adv;
    logic in_adv;
    logic fire;

    assign out_adv = !r_out_valid || !i_stall;
    assign fire    = r_in_valid && out_adv;
    assign in_adv  = !r_in_valid || out_adv;
    assign o_stall = !in_adv;

    lps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    lps_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_cfg          (cfg),
        .i_blue         (r_blue),
        .i_green        (r_green),
        .i_red          (r_red),
        .i_payload_byte (r_payload_byte),
        .o_result       (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_adv) begin
                r_in_valid <= i_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_valid) begin
            r_blue         <= i_blue_in;
            r_green        <= i_green_in;
            r_red          <= i_red_in;
            r_payload_byte <= i_payload_byte;
        end
        if (fire) begin
            r_result <= result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_blue_out       = r_result.blue;
    assign o_green_out      = r_result.green;
    assign o_red_out        = r_result.red;
    assign o_byte_out       = r_result.byte_out;
    assign o_byte_valid     = r_result.byte_valid;
    assign o_decoded_length = r_result.decoded_length;
    assign o_header_error   = r_result.header_error;
    assign o_last           = r_result.last;

endmodule

// ===== sim/lps_checker.sv =====
// ----------------------------------------------------------------------------
// lps_checker
// Watches the register port and both pixel channels of the stego codec. It
// keeps its own copy of the configuration and of the image position, length
// and error state, works out the outgoing pixel for each accepted input
// pixel, and compares every accepted output pixel field by field in order.
// ----------------------------------------------------------------------------
module lps_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [lps_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                       i_valid,
    input  logic                       i_in_stall,
    input  logic [lps_pkg::COMP_W-1:0] i_blue_in,
    input  logic [lps_pkg::COMP_W-1:0] i_green_in,
    input  logic [lps_pkg::COMP_W-1:0] i_red_in,
    input  logic [lps_pkg::COMP_W-1:0] i_payload_byte,
    input  logic                       i_out_valid,
    input  logic                       i_stall,
    input  logic [lps_pkg::COMP_W-1:0] i_blue_out,
    input  logic [lps_pkg::COMP_W-1:0] i_green_out,
    input  logic [lps_pkg::COMP_W-1:0] i_red_out,
    input  logic [lps_pkg::COMP_W-1:0] i_byte_out,
    input  logic                       i_byte_valid,
    input  logic [lps_pkg::DLEN_W-1:0] i_decoded_length,
    input  logic                       i_header_error,
    input  logic                       i_last,
    output int unsigned                o_fail_count,
    output int unsigned                o_pending
);
    import lps_pkg::*;

    t_result           expected_pixels[$];
    logic              embed_en;
    logic [PLEN_W-1:0] plen;
    logic [PCNT_W-1:0] pcnt;
    logic [PCNT_W-1:0] pix_idx;
    logic [DLEN_W-1:0] len_acc;
    logic              hdr_err;
    int unsigned       fails;
    int unsigned       pending;

    assign o_fail_count = fails;
    assign o_pending    = pending;

    task automatic predict_pixel(
        input  logic [COMP_W-1:0] b,
        input  logic [COMP_W-1:0] g,
        input  logic [COMP_W-1:0] r,
        input  logic [COMP_W-1:0] pb,
        output t_result           res
    );
        logic [PCNT_W:0]   count;
        logic [PCNT_W-1:0] off;
        logic [COMP_W-1:0] cb, cg, cr, v;
        logic              wr, is_last;
        int                bitpos;
        res     = '0;
        cb      = b;
        cg      = g;
        cr      = r;
        v       = '0;
        wr      = 1'b0;
        count   = (pcnt == '0) ? (PCNT_W+1)'(1) : {1'b0, pcnt};
        is_last = ({1'b0, pix_idx} >= count - (PCNT_W+1)'(1));
        off     = pix_idx - PCNT_W'(HDR_PIXELS);
        if (embed_en) begin
            if ({2'b00, plen} < count) begin
                if (pix_idx < HDR_PIXELS) begin
                    bitpos = int'(HDR_PIXELS) - 1 - int'(pix_idx);
                    v      = (bitpos < PLEN_W && plen[bitpos]) ? ASCII_1 : ASCII_0;
                    wr     = 1'b1;
                end else if ({1'b0, plen} > off) begin
                    v  = pb;
                    wr = 1'b1;
                end
                if (wr) begin
                    cb = (cb & MASK_BG) | {5'b0, v[2:0]};
                    cg = (cg & MASK_BG) | {5'b0, v[5:3]};
                    cr = (cr & MASK_R)  | {6'b0, v[7:6]};
                end
            end
        end else begin
            v = {r[1:0], g[2:0], b[2:0]};
            if (pix_idx < HDR_PIXELS) begin
                if (v == ASCII_0 || v == ASCII_1) begin
                    len_acc = {len_acc[DLEN_W-2:0], v[0]};
                end else begin
                    hdr_err = 1'b1;
                end
            end else if (!hdr_err && DLEN_W'(off) < len_acc) begin
                res.byte_valid = 1'b1;
            end
            res.decoded_length = len_acc;
            res.header_error   = hdr_err;
        end
        res.blue     = cb;
        res.green    = cg;
        res.red      = cr;
        res.byte_out = {cr[1:0], cg[2:0], cb[2:0]};
        res.last     = is_last;
        // wrap to the next image
        if (is_last) begin
            pix_idx = '0;
            len_acc = '0;
            hdr_err = 1'b0;
        end else begin
            pix_idx = pix_idx + 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            embed_en = 1'b0;
            plen     = '0;
            pcnt     = PCNT_W'(1);
            pix_idx  = '0;
            len_acc  = '0;
            hdr_err  = 1'b0;
            fails    = 0;
            expected_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_EMBED_MODE:     embed_en = i_cfg_wdata[0];
                    CFG_PAYLOAD_LENGTH: plen     = i_cfg_wdata[PLEN_W-1:0];
                    CFG_PIXEL_COUNT:    pcnt     = i_cfg_wdata[PCNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_stall) begin
                got = '{blue: i_blue_out, green: i_green_out, red: i_red_out,
                        byte_out: i_byte_out, byte_valid: i_byte_valid,
                        decoded_length: i_decoded_length,
                        header_error: i_header_error, last: i_last};
                if (expected_pixels.size() == 0) begin
                    if (fails < 10) begin
                        $display("unexpected output pixel: b=%h g=%h r=%h byte=%h",
                                 got.blue, got.green, got.red, got.byte_out);
                    end
                    fails++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (got !== want) begin
                        if (fails < 10) begin
                            $display({"pixel mismatch: expected b=%h g=%h r=%h byte=%h ",
                                      "bv=%b len=%h err=%b last=%b"},
                                     want.blue, want.green, want.red, want.byte_out,
                                     want.byte_valid, want.decoded_length,
                                     want.header_error, want.last);
                            $display({"                got      b=%h g=%h r=%h byte=%h ",
                                      "bv=%b len=%h err=%b last=%b"},
                                     got.blue, got.green, got.red, got.byte_out,
                                     got.byte_valid, got.decoded_length,
                                     got.header_error, got.last);
                        end
                        fails++;
                    end
                end
            end
            if (i_valid && !i_in_stall) begin
                predict_pixel(i_blue_in, i_green_in, i_red_in, i_payload_byte, want);
                expected_pixels = {expected_pixels, want};
            end
        end
        pending = expected_pixels.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the 3-3-2 LSB pixel stego codec. A short directed run hits
// the pixel count corner cases, header errors and embed pass-through, then
// random images follow, mostly with well-formed length headers, under
// random sender gaps and receiver stalls. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb_top;

    import lps_pkg::*;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_cfg_we       = 1'b0;
    logic [1:0]        i_cfg_index    = '0;
    logic [CFG_W-1:0]  i_cfg_wdata    = '0;
    logic              i_valid        = 1'b0;
    logic [COMP_W-1:0] i_blue_in      = '0;
    logic [COMP_W-1:0] i_green_in     = '0;
    logic [COMP_W-1:0] i_red_in       = '0;
    logic [COMP_W-1:0] i_payload_byte = '0;
    logic              i_stall        = 1'b0;

    logic              o_stall;
    logic              o_valid;
    logic [COMP_W-1:0] o_blue_out;
    logic [COMP_W-1:0] o_green_out;
    logic [COMP_W-1:0] o_red_out;
    logic [COMP_W-1:0] o_byte_out;
    logic              o_byte_valid;
    logic [DLEN_W-1:0] o_decoded_length;
    logic              o_header_error;
    logic              o_last;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned pixels_sent = 0;
    int unsigned stall_left  = 0;
    bit          idle_on     = 1'b1;

    lsb_pixel_stego_codec uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_blue_in        (i_blue_in),
        .i_green_in       (i_green_in),
        .i_red_in         (i_red_in),
        .i_payload_byte   (i_payload_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_blue_out       (o_blue_out),
        .o_green_out      (o_green_out),
        .o_red_out        (o_red_out),
        .o_byte_out       (o_byte_out),
        .o_byte_valid     (o_byte_valid),
        .o_decoded_length (o_decoded_length),
        .o_header_error   (o_header_error),
        .o_last           (o_last)
    );

    lps_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .i_in_stall       (o_stall),
        .i_blue_in        (i_blue_in),
        .i_green_in       (i_green_in),
        .i_red_in         (i_red_in),
        .i_payload_byte   (i_payload_byte),
        .i_out_valid      (o_valid),
        .i_stall          (i_stall),
        .i_blue_out       (o_blue_out),
        .i_green_out      (o_green_out),
        .i_red_out        (o_red_out),
        .i_byte_out       (o_byte_out),
        .i_byte_valid     (o_byte_valid),
        .i_decoded_length (o_decoded_length),
        .i_header_error   (o_header_error),
        .i_last           (o_last),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver stalls in bursts, their length set by a random stall_left
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 7);
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
    endtask

    task automatic setup_image(
        input logic              mode,
        input logic [PLEN_W-1:0] plen,
        input logic [PCNT_W-1:0] pcnt
    );
        write_reg(CFG_EMBED_MODE, CFG_W'(mode));
        write_reg(CFG_PAYLOAD_LENGTH, CFG_W'(plen));
        write_reg(CFG_PIXEL_COUNT, CFG_W'(pcnt));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_pixel(input logic [COMP_W-1:0] b, g, r, pb);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_blue_in      <= b;
        i_green_in     <= g;
        i_red_in       <= r;
        i_payload_byte <= pb;
        do @(posedge i_clk); while (o_stall);
        pixels_sent++;
    endtask

    task automatic push_random;
        push_pixel(COMP_W'($urandom), COMP_W'($urandom), COMP_W'($urandom),
                   COMP_W'($urandom));
    endtask

    // hide v in the low bits, keep the upper bits random
    task automatic push_hidden(input logic [COMP_W-1:0] v, input logic [COMP_W-1:0] pb);
        logic [COMP_W-1:0] hb, hg, hr;
        hb = COMP_W'($urandom);
        hg = COMP_W'($urandom);
        hr = COMP_W'($urandom);
        push_pixel({hb[7:3], v[2:0]}, {hg[7:3], v[5:3]}, {hr[7:2], v[7:6]}, pb);
    endtask

    task automatic run_image(
        input int unsigned       npix,
        input int unsigned       img,
        input logic [DLEN_W-1:0] hdr_len,
        input int unsigned       noise
    );
        int unsigned hp;
        for (int unsigned p = 0; p < npix; p++) begin
            hp = p % img;
            if (hp < HDR_PIXELS && $urandom_range(0, 99) >= noise) begin
                push_hidden(hdr_len[31-hp] ? ASCII_1 : ASCII_0, COMP_W'($urandom));
            end else begin
                push_random();
            end
        end
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        logic              mode;
        logic [PLEN_W-1:0] plen;
        logic [PCNT_W-1:0] pcnt;
        logic [DLEN_W-1:0] hdr_len;
        int unsigned       sel, npix, img, noise;
        bit                big;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero pixel count: every pixel is the last one
        setup_image(1'b0, '0, '0);
        push_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        drain();

        // short image with a bad header character
        setup_image(1'b0, '0, PCNT_W'(5));
        push_hidden(ASCII_1, 8'h00);
        push_hidden(ASCII_0, 8'hFF);
        push_hidden(8'hFF, 8'h5A);
        push_hidden(ASCII_1, 8'hA5);
        push_pixel(8'h00, 8'hFF, 8'h00, 8'hFF);
        drain();

        // embed header into a short image
        setup_image(1'b1, PLEN_W'(3), PCNT_W'(4));
        push_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        push_pixel(8'hAA, 8'h55, 8'hAA, 8'h55);
        push_pixel(8'h55, 8'hAA, 8'h55, 8'hAA);
        drain();

        // payload too long: pass through
        setup_image(1'b1, PLEN_W'(4), PCNT_W'(4));
        push_pixel(8'h00, 8'hFF, 8'h00, 8'hFF);
        push_pixel(8'hFF, 8'h00, 8'hFF, 8'h00);
        drain();

        // count lowered below the position
        setup_image(1'b1, PLEN_W'(4), PCNT_W'(1));
        push_pixel(8'h12, 8'h34, 8'h56, 8'h78);
        drain();

        // widest length, largest image
        setup_image(1'b1, PLEN_W'(24'hFFFFFF), PCNT_W'(25'h1000000));
        push_pixel(8'h00, 8'h00, 8'h00, 8'hFF);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);
        drain();
        setup_image(1'b0, '0, PCNT_W'(1));
        push_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        drain();

        while (pixels_sent < 900) begin
            idle_on <= (pixels_sent < 760) && ($urandom_range(0, 4) != 0);
            mode = 1'($urandom_range(0, 1));
            sel  = $urandom_range(0, 9);
            big  = 1'b0;
            if (sel < 6) begin
                pcnt = PCNT_W'($urandom_range(33, 72));
            end else if (sel < 8) begin
                pcnt = PCNT_W'($urandom_range(1, 40));
            end else if (sel == 8) begin
                pcnt = ($urandom_range(0, 1) != 0) ? PCNT_W'(25'h1000000)
                                                   : PCNT_W'($urandom_range(100, 25'h1000000));
                big  = 1'b1;
            end else if ($urandom_range(0, 1) != 0) begin
                pcnt = '0;
            end else begin
                pcnt = '1;
                big  = 1'b1;
            end
            case ($urandom_range(0, 3))
                0:       plen = '0;
                3:       plen = PLEN_W'($urandom);
                default: plen = PLEN_W'($urandom_range(0, 45));
            endcase
            hdr_len = ($urandom_range(0, 4) == 0) ? DLEN_W'($urandom)
                                                  : DLEN_W'($urandom_range(0, 45));
            noise = mode ? 100 : (($urandom_range(0, 4) == 0) ? 10 : 0);
            img   = (pcnt == '0) ? 1 : int'(pcnt);
            npix  = big ? $urandom_range(40, 80)
                        : img * $urandom_range(1, (pcnt == '0) ? 4 : 2);
            setup_image(mode, plen, pcnt);
            run_image(npix, img, hdr_len, noise);
            drain();
            // close the open image so the next header starts at pixel zero
            if (big) begin
                setup_image(mode, plen, PCNT_W'(1));
                push_random();
                drain();
            end
        end

        if (fail_count == 0 && pending == 0) begin
            $display("lsb_pixel_stego_codec test passed");
        end else begin
            $display("lsb_pixel_stego_codec test failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("lsb_pixel_stego_codec test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lps_pkg.sv
rtl/lps_cfg.sv
rtl/lps_core.sv
rtl/lsb_pixel_stego_codec.sv
sim/lps_checker.sv
sim/tb_top.sv
